### hdl/spnh_pkg.sv
`timescale 1ns / 1ps
package spnh_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int SHAPE_BITS_DEF = 8;

    typedef struct packed {
        logic first;
        logic last;
        logic last_shape;
    } t_flags;

endpackage

### hdl/spnh_if.sv
`timescale 1ns / 1ps
interface spnh_in_if #(
    parameter int CW = spnh_pkg::COORD_BITS_DEF,
    parameter int SW = spnh_pkg::SHAPE_BITS_DEF
);
    logic              valid;
    logic              ready;
    logic signed [CW-1:0] origin_x;
    logic signed [CW-1:0] origin_y;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
    logic signed [CW-1:0] corner_x;
    logic signed [CW-1:0] corner_y;
    logic              first_corner;
    logic              last_corner;
    logic              last_shape;
    logic [SW-1:0]     shape_index;

    modport source (
        output valid, origin_x, origin_y, end_x, end_y, corner_x, corner_y,
               first_corner, last_corner, last_shape, shape_index,
        input  ready
    );
    modport sink (
        input  valid, origin_x, origin_y, end_x, end_y, corner_x, corner_y,
               first_corner, last_corner, last_shape, shape_index,
        output ready
    );
endinterface

interface spnh_out_if #(
    parameter int CW = spnh_pkg::COORD_BITS_DEF,
    parameter int SW = spnh_pkg::SHAPE_BITS_DEF
);
    logic              valid;
    logic              ready;
    logic              hit_found;
    logic signed [CW-1:0] hit_x;
    logic signed [CW-1:0] hit_y;
    logic [SW-1:0]     hit_shape;

    modport source (output valid, hit_found, hit_x, hit_y, hit_shape, input ready);
    modport sink (input valid, hit_found, hit_x, hit_y, hit_shape, output ready);
endinterface

### hdl/segment_polygon_nearest_hit_top.sv
`timescale 1ns / 1ps
// Channel   Dir   Beat contents
// i_item    in    segment origin/end, one polygon corner, corner/shape marks, shape index
// o_res     out   hit flag, nearest hit point, hit shape index
//
// A first corner that is not also a last corner only clears the shape best in the back
// end. Each edge test forms the differences and cross products, checks sign and range,
// and on a pass compares its ratio with the shape best. A last corner of a shape with a
// hit adds the hit point work: the shared radix-2 divider and a compare with the query best.
// Reset is synchronous and clears the queue, the corner history and both bests.
// A 2-beat queue and a result register let either side stall on its own.
module segment_polygon_nearest_hit_top #(
    parameter int COORD_BITS = spnh_pkg::COORD_BITS_DEF,
    parameter int SHAPE_BITS = spnh_pkg::SHAPE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spnh_in_if.sink     i_item,
    spnh_out_if.source  o_res
);
    import spnh_pkg::*;

    logic                         w_q_valid;
    logic                         w_q_pop;
    logic signed [COORD_BITS-1:0] w_ox, w_oy, w_ex, w_ey, w_cx, w_cy;
    logic signed [COORD_BITS-1:0] w_px, w_py, w_sx, w_sy;
    t_flags                       w_flags;
    logic [SHAPE_BITS-1:0]        w_sidx;

    spnh_front #(.CW(COORD_BITS), .SW(SHAPE_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .o_q_valid(w_q_valid),
        .i_q_pop  (w_q_pop),
        .o_ox     (w_ox),
        .o_oy     (w_oy),
        .o_ex     (w_ex),
        .o_ey     (w_ey),
        .o_cx     (w_cx),
        .o_cy     (w_cy),
        .o_px     (w_px),
        .o_py     (w_py),
        .o_sx     (w_sx),
        .o_sy     (w_sy),
        .o_flags  (w_flags),
        .o_sidx   (w_sidx)
    );

    spnh_back #(.CW(COORD_BITS), .SW(SHAPE_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(w_q_valid),
        .o_q_pop  (w_q_pop),
        .i_ox     (w_ox),
        .i_oy     (w_oy),
        .i_ex     (w_ex),
        .i_ey     (w_ey),
        .i_cx     (w_cx),
        .i_cy     (w_cy),
        .i_px     (w_px),
        .i_py     (w_py),
        .i_sx     (w_sx),
        .i_sy     (w_sy),
        .i_flags  (w_flags),
        .i_sidx   (w_sidx),
        .o_res    (o_res)
    );

endmodule

### hdl/spnh_front.sv
`timescale 1ns / 1ps
module spnh_front #(
    parameter int CW = spnh_pkg::COORD_BITS_DEF,
    parameter int SW = spnh_pkg::SHAPE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    spnh_in_if.sink              i_item,
    output logic                 o_q_valid,
    input  logic                 i_q_pop,
    output logic signed [CW-1:0] o_ox,
    output logic signed [CW-1:0] o_oy,
    output logic signed [CW-1:0] o_ex,
    output logic signed [CW-1:0] o_ey,
    output logic signed [CW-1:0] o_cx,
    output logic signed [CW-1:0] o_cy,
    output logic signed [CW-1:0] o_px,
    output logic signed [CW-1:0] o_py,
    output logic signed [CW-1:0] o_sx,
    output logic signed [CW-1:0] o_sy,
    output spnh_pkg::t_flags     o_flags,
    output logic [SW-1:0]        o_sidx
);
    import spnh_pkg::*;

    localparam int EW = 10 * CW + 3 + SW;

    logic [EW-1:0]        r_mem [2];
    logic                 r_wp;
    logic                 r_rp;
    logic [1:0]           r_cnt;
    logic signed [CW-1:0] r_prev_x;
    logic signed [CW-1:0] r_prev_y;
    logic signed [CW-1:0] r_start_x;
    logic signed [CW-1:0] r_start_y;
    logic signed [CW-1:0] w_sx;
    logic signed [CW-1:0] w_sy;
    logic [EW-1:0]        w_entry;
    logic                 w_push;

    // The start corner travels with every beat so that the closing edge
    // sees the corner stored by this beat when it is a first corner.
    assign w_sx = i_item.first_corner ? i_item.corner_x : r_start_x;
    assign w_sy = i_item.first_corner ? i_item.corner_y : r_start_y;
    assign i_item.ready = (r_cnt != 2'd2);
    assign w_push = i_item.valid && i_item.ready;
    assign w_entry = {i_item.origin_x, i_item.origin_y, i_item.end_x, i_item.end_y,
                      i_item.corner_x, i_item.corner_y, r_prev_x, r_prev_y, w_sx, w_sy,
                      i_item.first_corner, i_item.last_corner, i_item.last_shape,
                      i_item.shape_index};

    assign o_q_valid = (r_cnt != 2'd0);
    assign {o_ox, o_oy, o_ex, o_ey, o_cx, o_cy, o_px, o_py, o_sx, o_sy, o_flags, o_sidx}
        = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_entry;
        end
        if (!i_rst_n) begin
            r_wp      <= 1'b0;
            r_rp      <= 1'b0;
            r_cnt     <= 2'd0;
            r_prev_x  <= '0;
            r_prev_y  <= '0;
            r_start_x <= '0;
            r_start_y <= '0;
        end else begin
            if (w_push) begin
                r_wp     <= ~r_wp;
                r_prev_x <= i_item.corner_x;
                r_prev_y <= i_item.corner_y;
                r_start_x <= w_sx;
                r_start_y <= w_sy;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end

endmodule

### hdl/spnh_back.sv
`timescale 1ns / 1ps
module spnh_back #(
    parameter int CW = spnh_pkg::COORD_BITS_DEF,
    parameter int SW = spnh_pkg::SHAPE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    output logic                 o_q_pop,
    input  logic signed [CW-1:0] i_ox,
    input  logic signed [CW-1:0] i_oy,
    input  logic signed [CW-1:0] i_ex,
    input  logic signed [CW-1:0] i_ey,
    input  logic signed [CW-1:0] i_cx,
    input  logic signed [CW-1:0] i_cy,
    input  logic signed [CW-1:0] i_px,
    input  logic signed [CW-1:0] i_py,
    input  logic signed [CW-1:0] i_sx,
    input  logic signed [CW-1:0] i_sy,
    input  spnh_pkg::t_flags     i_flags,
    input  logic [SW-1:0]        i_sidx,
    spnh_out_if.source           o_res
);
    import spnh_pkg::*;

    localparam int DW  = CW + 1;
    localparam int ND  = 2 * CW + 4;
    localparam int H   = ND / 2;
    localparam int QB  = CW + 1;
    localparam int AW  = 2 * ND + 1;
    localparam int MW  = ND + H;
    localparam int STW = $clog2(QB + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIFF, ST_MUL, ST_SIGN, ST_CHECK, ST_RCMP, ST_RDONE, ST_NEXT,
        ST_FIN, ST_PMUL, ST_PDIV, ST_PCHK, ST_CLEAR, ST_OUT
    } t_state;

    typedef enum logic {CTX_EDGE, CTX_FIN} t_ctx;

    t_state               r_state;
    t_ctx                 r_ctx;
    logic [STW-1:0]       r_step;
    logic signed [CW-1:0] r_ox, r_oy, r_ex, r_ey, r_cx, r_cy, r_px, r_py, r_sx, r_sy;
    t_flags               r_flags;
    logic [SW-1:0]        r_sidx;
    logic                 r_edge_b;
    logic signed [DW-1:0] r_dpx, r_dpy, r_qax, r_qay, r_qbx, r_qby;
    logic signed [ND-1:0] r_d, r_na, r_nb;
    logic [ND-1:0]        r_ra, r_rb, r_rc, r_re;
    logic signed [AW-1:0] r_acc;
    logic [ND-1:0]        r_snum, r_sden;
    logic                 r_sfound;
    logic [ND-1:0]        r_bnum, r_bden;
    logic                 r_bfound;
    logic [SW-1:0]        r_bshape;
    logic signed [CW-1:0] r_bpx, r_bpy;
    logic signed [CW-1:0] r_ptx, r_pty;
    logic                 r_k;
    logic [ND-1:0]        r_rem;
    logic [QB-1:0]        r_low;
    logic [QB-1:0]        r_q;
    logic [QB-1:0]        r_p0;
    logic                 r_out_valid;
    logic                 r_out_found;
    logic signed [CW-1:0] r_out_x, r_out_y;
    logic [SW-1:0]        r_out_shape;

    logic signed [CW-1:0]   w_ax, w_ay, w_bx, w_by;
    logic signed [DW-1:0]   w_ma, w_mb;
    logic signed [2*DW-1:0] w_sprod;
    logic signed [ND-1:0]   w_sprod_x;
    logic [ND-1:0]          w_ua;
    logic [H-1:0]           w_ub;
    logic [MW-1:0]          w_uprod;
    logic signed [AW-1:0]   w_term;
    logic signed [DW-1:0]   w_qx, w_qy, w_q;
    logic [DW-1:0]          w_mag;
    logic [ND:0]            w_trial, w_sub;
    logic                   w_ge;
    logic [DW:0]            w_ptx, w_pty;
    logic                   w_less;

    assign o_q_pop = (r_state == ST_IDLE) && i_q_valid;

    assign w_ax = r_edge_b ? r_cx : r_px;
    assign w_ay = r_edge_b ? r_cy : r_py;
    assign w_bx = r_edge_b ? r_sx : r_cx;
    assign w_by = r_edge_b ? r_sy : r_cy;

    always_comb begin
        case (r_step[2:0])
            3'd0: begin w_ma = r_qay; w_mb = r_qbx; end
            3'd1: begin w_ma = r_qby; w_mb = r_qax; end
            3'd2: begin w_ma = r_qbx; w_mb = r_dpy; end
            3'd3: begin w_ma = r_qby; w_mb = r_dpx; end
            3'd4: begin w_ma = r_qax; w_mb = r_dpy; end
            default: begin w_ma = r_qay; w_mb = r_dpx; end
        endcase
    end
    assign w_sprod   = w_ma * w_mb;
    assign w_sprod_x = ND'(w_sprod);

    assign w_qx  = DW'(r_ex) - DW'(r_ox);
    assign w_qy  = DW'(r_ey) - DW'(r_oy);
    assign w_q   = r_k ? w_qy : w_qx;
    assign w_mag = w_q[DW-1] ? DW'(-w_q) : DW'(w_q);

    always_comb begin
        if (r_state == ST_RCMP) begin
            case (r_step[1:0])
                2'd0: begin w_ua = r_ra; w_ub = r_re[H-1:0]; end
                2'd1: begin w_ua = r_ra; w_ub = r_re[ND-1:H]; end
                2'd2: begin w_ua = r_rc; w_ub = r_rb[H-1:0]; end
                default: begin w_ua = r_rc; w_ub = r_rb[ND-1:H]; end
            endcase
        end else begin
            w_ua = r_snum;
            w_ub = H'(w_mag);
        end
    end
    assign w_uprod = w_ua * w_ub;
    assign w_term  = r_step[0] ? (AW'(w_uprod) << H) : AW'(w_uprod);
    assign w_less  = r_acc[AW-1];

    assign w_trial = {r_rem, r_low[QB-1]};
    assign w_sub   = w_trial - {1'b0, r_sden};
    assign w_ge    = (w_trial >= {1'b0, r_sden});

    assign w_ptx = w_qx[DW-1] ? ((DW+1)'(r_ox) - {1'b0, r_p0})
                              : ((DW+1)'(r_ox) + {1'b0, r_p0});
    assign w_pty = w_qy[DW-1] ? ((DW+1)'(r_oy) - {1'b0, r_q})
                              : ((DW+1)'(r_oy) + {1'b0, r_q});

    assign o_res.valid     = r_out_valid;
    assign o_res.hit_found = r_out_found;
    assign o_res.hit_x     = r_out_x;
    assign o_res.hit_y     = r_out_y;
    assign o_res.hit_shape = r_out_shape;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_snum      <= ND'(1);
            r_sden      <= ND'(1);
            r_sfound    <= 1'b0;
            r_bnum      <= ND'(1);
            r_bden      <= ND'(1);
            r_bfound    <= 1'b0;
            r_bshape    <= '0;
            r_bpx       <= '0;
            r_bpy       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_res.ready && (r_state != ST_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_ox <= i_ox; r_oy <= i_oy; r_ex <= i_ex; r_ey <= i_ey;
                        r_cx <= i_cx; r_cy <= i_cy; r_px <= i_px; r_py <= i_py;
                        r_sx <= i_sx; r_sy <= i_sy;
                        r_flags <= i_flags;
                        r_sidx  <= i_sidx;
                        if (i_flags.first) begin
                            r_snum   <= ND'(1);
                            r_sden   <= ND'(1);
                            r_sfound <= 1'b0;
                        end
                        if (!i_flags.first) begin
                            r_edge_b <= 1'b0;
                            r_state  <= ST_DIFF;
                        end else if (i_flags.last) begin
                            r_edge_b <= 1'b1;
                            r_state  <= ST_DIFF;
                        end
                    end
                end
                ST_DIFF: begin
                    r_dpx  <= DW'(w_ax) - DW'(r_ox);
                    r_dpy  <= DW'(w_ay) - DW'(r_oy);
                    r_qax  <= DW'(r_ex) - DW'(r_ox);
                    r_qay  <= DW'(r_ey) - DW'(r_oy);
                    r_qbx  <= DW'(w_bx) - DW'(w_ax);
                    r_qby  <= DW'(w_by) - DW'(w_ay);
                    r_step <= '0;
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    case (r_step[2:0])
                        3'd0: r_d  <= w_sprod_x;
                        3'd1: r_d  <= r_d - w_sprod_x;
                        3'd2: r_na <= w_sprod_x;
                        3'd3: r_na <= r_na - w_sprod_x;
                        3'd4: r_nb <= w_sprod_x;
                        default: r_nb <= r_nb - w_sprod_x;
                    endcase
                    r_step <= r_step + 1'b1;
                    if (r_step == STW'(5)) begin
                        r_state <= ST_SIGN;
                    end
                end
                ST_SIGN: begin
                    if (r_d < 0) begin
                        r_d  <= -r_d;
                        r_na <= -r_na;
                        r_nb <= -r_nb;
                    end
                    r_state <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (r_d == 0 || r_na < 0 || r_nb < 0 || r_nb > r_d) begin
                        r_state <= ST_NEXT;
                    end else begin
                        r_ra    <= r_na;
                        r_rb    <= r_d;
                        r_rc    <= r_snum;
                        r_re    <= r_sden;
                        r_ctx   <= CTX_EDGE;
                        r_acc   <= '0;
                        r_step  <= '0;
                        r_state <= ST_RCMP;
                    end
                end
                ST_RCMP: begin
                    r_acc  <= r_step[1] ? (r_acc - w_term) : (r_acc + w_term);
                    r_step <= r_step + 1'b1;
                    if (r_step == STW'(3)) begin
                        r_state <= ST_RDONE;
                    end
                end
                ST_RDONE: begin
                    if (r_ctx == CTX_EDGE) begin
                        if (w_less) begin
                            r_snum   <= r_ra;
                            r_sden   <= r_rb;
                            r_sfound <= 1'b1;
                        end
                        r_state <= ST_NEXT;
                    end else begin
                        if (w_less) begin
                            r_bnum   <= r_snum;
                            r_bden   <= r_sden;
                            r_bfound <= 1'b1;
                            r_bshape <= r_sidx;
                            r_bpx    <= r_ptx;
                            r_bpy    <= r_pty;
                        end
                        r_state <= ST_CLEAR;
                    end
                end
                ST_NEXT: begin
                    if (r_edge_b) begin
                        r_state <= ST_FIN;
                    end else if (r_flags.last) begin
                        r_edge_b <= 1'b1;
                        r_state  <= ST_DIFF;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_FIN: begin
                    r_k     <= 1'b0;
                    r_state <= r_sfound ? ST_PMUL : ST_CLEAR;
                end
                ST_PMUL: begin
                    r_rem   <= w_uprod[QB+ND-1:QB];
                    r_low   <= w_uprod[QB-1:0];
                    r_step  <= '0;
                    r_state <= ST_PDIV;
                end
                ST_PDIV: begin
                    r_rem  <= w_ge ? w_sub[ND-1:0] : w_trial[ND-1:0];
                    r_low  <= r_low << 1;
                    r_q    <= {r_q[QB-2:0], w_ge};
                    r_step <= r_step + 1'b1;
                    if (r_step == STW'(QB - 1)) begin
                        if (!r_k) begin
                            r_k     <= 1'b1;
                            r_state <= ST_PMUL;
                        end else begin
                            r_state <= ST_PCHK;
                        end
                    end
                    if (r_step == STW'(QB - 1) && !r_k) begin
                        r_p0 <= {r_q[QB-2:0], w_ge};
                    end
                end
                ST_PCHK: begin
                    r_ptx <= w_ptx[CW-1:0];
                    r_pty <= w_pty[CW-1:0];
                    if (!w_ptx[DW] && !w_pty[DW]) begin
                        r_ra    <= r_snum;
                        r_rb    <= r_sden;
                        r_rc    <= r_bnum;
                        r_re    <= r_bden;
                        r_ctx   <= CTX_FIN;
                        r_acc   <= '0;
                        r_step  <= '0;
                        r_state <= ST_RCMP;
                    end else begin
                        r_state <= ST_CLEAR;
                    end
                end
                ST_CLEAR: begin
                    r_snum   <= ND'(1);
                    r_sden   <= ND'(1);
                    r_sfound <= 1'b0;
                    r_state  <= r_flags.last_shape ? ST_OUT : ST_IDLE;
                end
                ST_OUT: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_found <= r_bfound;
                        r_out_x     <= r_bfound ? r_bpx : r_ex;
                        r_out_y     <= r_bfound ? r_bpy : r_ey;
                        r_out_shape <= r_bfound ? r_bshape : '0;
                        r_bnum      <= ND'(1);
                        r_bden      <= ND'(1);
                        r_bfound    <= 1'b0;
                        r_bshape    <= '0;
                        r_bpx       <= '0;
                        r_bpy       <= '0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

### hdl/spnh_checker.sv
`timescale 1ns / 1ps
module spnh_checker #(
    parameter int CW = spnh_pkg::COORD_BITS_DEF,
    parameter int SW = spnh_pkg::SHAPE_BITS_DEF
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 i_ready,
    input logic                 i_found,
    input logic signed [CW-1:0] i_x,
    input logic signed [CW-1:0] i_y,
    input logic [SW-1:0]        i_shape
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result beat dropped while stalled");

    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_found) && $stable(i_x) && $stable(i_y)
                                && $stable(i_shape))
        else $error("result beat changed while stalled");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    a_no_hit_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_found |-> i_shape == '0)
        else $error("shape index reported without a hit");

    a_hit_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_found |-> !i_x[CW-1] && !i_y[CW-1])
        else $error("hit point has a negative coordinate");

endmodule

bind segment_polygon_nearest_hit_top spnh_checker #(
    .CW(COORD_BITS),
    .SW(SHAPE_BITS)
) u_chk (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .i_valid(o_res.valid),
    .i_ready(o_res.ready),
    .i_found(o_res.hit_found),
    .i_x    (o_res.hit_x),
    .i_y    (o_res.hit_y),
    .i_shape(o_res.hit_shape)
);

### verif/tb_segment_polygon_nearest_hit_top.sv
`timescale 1ns / 1ps
module tb_segment_polygon_nearest_hit_top;

    typedef struct {
        logic signed [15:0] ox, oy, ex, ey, cx, cy;
        bit                 first, last, lshape;
        logic [7:0]         idx;
    } corner_t;

    typedef struct {
        bit          found;
        logic [15:0] x, y;
        logic [7:0]  shape;
    } hit_t;

    typedef struct {
        corner_t c;
        bit      typed;
        hit_t    want;
    } row_t;

    logic i_clk;
    logic i_rst_n;

    spnh_in_if  item_if ();
    spnh_out_if res_if ();

    segment_polygon_nearest_hit_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_res   (res_if)
    );

    longint      prev_x, prev_y, start_x, start_y;
    logic [63:0] shp_num, shp_den, qry_num, qry_den;
    bit          shp_found, qry_found;
    logic [7:0]  qry_shape;
    longint      qry_px, qry_py;

    hit_t hit_q[$];
    int   errors = 0;
    row_t rows[$];
    int   stall_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic bit ratio_below(logic [63:0] a, logic [63:0] b,
                                       logic [63:0] c, logic [63:0] e);
        logic [127:0] l, r;
        l = {64'd0, a} * {64'd0, e};
        r = {64'd0, c} * {64'd0, b};
        return l < r;
    endfunction

    function automatic void clear_query();
        qry_num = 1;
        qry_den = 1;
        qry_found = 0;
        qry_shape = 0;
        qry_px = 0;
        qry_py = 0;
    endfunction

    function automatic void cross_edge(longint ox, longint oy, longint ex, longint ey,
                                       longint ax, longint ay, longint bx, longint by);
        longint dpx, dpy, qax, qay, qbx, qby, d, na, nb;
        dpx = ax - ox;
        dpy = ay - oy;
        qax = ex - ox;
        qay = ey - oy;
        qbx = bx - ax;
        qby = by - ay;
        d = qay * qbx - qby * qax;
        na = qbx * dpy - qby * dpx;
        nb = qax * dpy - qay * dpx;
        if (d == 0) return;
        if (d < 0) begin
            d = -d;
            na = -na;
            nb = -nb;
        end
        if (na < 0 || nb < 0 || nb > d) return;
        if (ratio_below(na, d, shp_num, shp_den)) begin
            shp_num = na;
            shp_den = d;
            shp_found = 1;
        end
    endfunction

    function automatic longint hit_coord(longint o, longint e);
        longint       q;
        logic [63:0]  mag;
        logic [127:0] p;
        q = e - o;
        mag = (q < 0) ? -q : q;
        p = ({64'd0, shp_num} * {64'd0, mag}) / {64'd0, shp_den};
        return (q < 0) ? o - longint'(p[63:0]) : o + longint'(p[63:0]);
    endfunction

    function automatic bit predict_hit(corner_t c, output hit_t h);
        longint ox, oy, ex, ey, cx, cy, px, py;
        ox = c.ox; oy = c.oy; ex = c.ex; ey = c.ey; cx = c.cx; cy = c.cy;
        h = '{0, 0, 0, 0};
        if (c.first) begin
            start_x = cx;
            start_y = cy;
            shp_num = 1; shp_den = 1; shp_found = 0;
        end else begin
            cross_edge(ox, oy, ex, ey, prev_x, prev_y, cx, cy);
        end
        prev_x = cx;
        prev_y = cy;
        if (!c.last) return 0;
        cross_edge(ox, oy, ex, ey, cx, cy, start_x, start_y);
        if (shp_found) begin
            px = hit_coord(ox, ex);
            py = hit_coord(oy, ey);
            if (px >= 0 && py >= 0 && ratio_below(shp_num, shp_den, qry_num, qry_den)) begin
                qry_num = shp_num;
                qry_den = shp_den;
                qry_found = 1;
                qry_shape = c.idx;
                qry_px = px;
                qry_py = py;
            end
        end
        shp_num = 1; shp_den = 1; shp_found = 0;
        if (!c.lshape) return 0;
        h.found = qry_found;
        h.x = qry_found ? qry_px[15:0] : c.ex;
        h.y = qry_found ? qry_py[15:0] : c.ey;
        h.shape = qry_found ? qry_shape : 8'd0;
        clear_query();
        return 1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_corner(corner_t c, int gap, bit typed, hit_t want);
        hit_t h;
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid        <= 1'b1;
        item_if.origin_x     <= c.ox;
        item_if.origin_y     <= c.oy;
        item_if.end_x        <= c.ex;
        item_if.end_y        <= c.ey;
        item_if.corner_x     <= c.cx;
        item_if.corner_y     <= c.cy;
        item_if.first_corner <= c.first;
        item_if.last_corner  <= c.last;
        item_if.last_shape   <= c.lshape;
        item_if.shape_index  <= c.idx;
        do @(posedge i_clk); while (!item_if.ready);
        if (predict_hit(c, h)) hit_q.insert(hit_q.size(), typed ? want : h);
    endtask

    task automatic drain();
        while (hit_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic corner_t mk(int ox, int oy, int ex, int ey, int cx, int cy,
                                   bit f, bit l, bit s, int idx);
        corner_t c;
        c.ox = 16'(ox); c.oy = 16'(oy); c.ex = 16'(ex); c.ey = 16'(ey);
        c.cx = 16'(cx); c.cy = 16'(cy);
        c.first = f; c.last = l; c.lshape = s; c.idx = 8'(idx);
        return c;
    endfunction

    function automatic void add_row(corner_t c, bit typed = 0, hit_t want = '{0, 0, 0, 0});
        row_t rw;
        rw = '{c, typed, want};
        rows.insert(rows.size(), rw);
    endfunction

    function automatic logic signed [15:0] rnd_coord(int mode);
        case (mode)
            0: return 16'($urandom_range(0, 4000));
            1: return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 4000)) - 1000);
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (res_if.valid && res_if.ready) begin
            if (hit_q.size() == 0) begin
                $display("%0t: unexpected result found=%0b x=%0d y=%0d shape=%0d",
                         $time, res_if.hit_found, res_if.hit_x, res_if.hit_y,
                         res_if.hit_shape);
                errors++;
            end else begin
                hit_t w;
                w = hit_q.pop_front();
                if (res_if.hit_found !== w.found) begin
                    $display("%0t: hit_found expected %0b actual %0b",
                             $time, w.found, res_if.hit_found);
                    errors++;
                end
                if (res_if.hit_x !== w.x) begin
                    $display("%0t: hit_x expected %0d actual %0d",
                             $time, $signed(w.x), res_if.hit_x);
                    errors++;
                end
                if (res_if.hit_y !== w.y) begin
                    $display("%0t: hit_y expected %0d actual %0d",
                             $time, $signed(w.y), res_if.hit_y);
                    errors++;
                end
                if (res_if.hit_shape !== w.shape) begin
                    $display("%0t: hit_shape expected %0d actual %0d",
                             $time, w.shape, res_if.hit_shape);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 15) begin
                res_if.ready <= 1'b1;
                stall_left <= 200;
            end else if (r < 75) begin
                res_if.ready <= 1'b1;
                stall_left <= $urandom_range(0, 5);
            end else if (r < 95) begin
                res_if.ready <= 1'b0;
                stall_left <= $urandom_range(0, 4);
            end else begin
                res_if.ready <= 1'b0;
                stall_left <= $urandom_range(20, 80);
            end
        end
    end

    initial begin
        corner_t c;
        hit_t    none;
        int      sent, mode, nshape, ncorn, cxc, cyc, rad;
        logic signed [15:0] ox, oy, ex, ey;
        bit      calm;
        bit      drained;

        drained = 1'b0;
        prev_x = 0; prev_y = 0; start_x = 0; start_y = 0;
        shp_num = 1; shp_den = 1; shp_found = 0;
        clear_query();

        i_rst_n <= 1'b0;
        item_if.valid <= 1'b0;
        item_if.origin_x <= '0;
        item_if.origin_y <= '0;
        item_if.end_x <= '0;
        item_if.end_y <= '0;
        item_if.corner_x <= '0;
        item_if.corner_y <= '0;
        item_if.first_corner <= 1'b0;
        item_if.last_corner <= 1'b0;
        item_if.last_shape <= 1'b0;
        item_if.shape_index <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Missing first mark right after reset: the edge starts at the stored origin.
        add_row(mk(-16, 8, 64, 8, 0, 32, 0, 0, 0, 3));
        add_row(mk(-16, 8, 64, 8, 32, 0, 0, 1, 1, 3));
        none = '{0, 16'd200, 16'd100, 8'd0};
        add_row(mk(0, 0, 200, 100, 7, 7, 1, 1, 1, 5), 1, none);
        add_row(mk(0, 0, 160, 160, 80, 0, 1, 0, 1, 9));
        add_row(mk(0, 0, 160, 160, 80, 160, 0, 0, 0, 9));
        add_row(mk(0, 0, 160, 160, 0, 80, 0, 1, 0, 9));
        add_row(mk(0, 0, 160, 160, 40, 0, 1, 0, 0, 255));
        add_row(mk(0, 0, 160, 160, 40, 0, 0, 0, 0, 255));
        add_row(mk(0, 0, 160, 160, 0, 40, 0, 1, 1, 255));
        add_row(mk(-32768, -32768, 32767, 32767, -32768, 32767, 1, 0, 0, 0));
        add_row(mk(-32768, -32768, 32767, 32767, 32767, -32768, 0, 0, 0, 0));
        add_row(mk(-32768, -32768, 32767, 32767, 32767, 32767, 0, 1, 1, 0));
        add_row(mk(32767, 32767, -32768, -32768, 0, -32768, 1, 0, 0, 128));
        add_row(mk(32767, 32767, -32768, -32768, 0, 32767, 0, 1, 1, 128));
        none = '{0, 16'd50, 16'd50, 8'd0};
        add_row(mk(50, 50, 50, 50, 0, 0, 1, 0, 0, 1));
        add_row(mk(50, 50, 50, 50, 100, 100, 0, 0, 0, 1));
        add_row(mk(50, 50, 50, 50, 0, 100, 0, 1, 1, 1), 1, none);
        add_row(mk(0, 16, 320, 16, 100, 0, 1, 0, 0, 7));
        add_row(mk(0, 16, 320, 16, 100, 100, 0, 0, 0, 7));
        add_row(mk(0, 16, 320, 16, 200, 0, 0, 1, 0, 8));
        add_row(mk(0, 16, 320, 16, 200, 100, 1, 0, 0, 170));
        add_row(mk(0, 16, 320, 16, 200, 0, 0, 1, 1, 170));

        sent = 0;
        foreach (rows[i]) begin
            send_corner(rows[i].c, pick_gap(), rows[i].typed, rows[i].want);
            sent++;
        end

        while (sent < 1400) begin
            if (!drained && sent > 700) begin
                drained = 1'b1;
                item_if.valid <= 1'b0;
                drain();
            end
            calm = ($urandom_range(0, 9) == 0);
            mode = $urandom_range(0, 9);
            mode = (mode < 7) ? 0 : (mode < 9) ? 1 : 2;
            ox = rnd_coord(mode); oy = rnd_coord(mode);
            ex = rnd_coord(mode); ey = rnd_coord(mode);
            nshape = $urandom_range(1, 4);
            for (int s = 0; s < nshape; s++) begin
                int idx;
                idx = $urandom_range(0, 255);
                ncorn = $urandom_range(1, 6);
                cxc = $urandom_range(0, 4000);
                cyc = $urandom_range(0, 4000);
                rad = $urandom_range(16, 1500);
                if ($urandom_range(0, 19) == 0) begin
                    ox = rnd_coord(mode); oy = rnd_coord(mode);
                end
                for (int k = 0; k < ncorn; k++) begin
                    c.ox = ox; c.oy = oy; c.ex = ex; c.ey = ey;
                    if (mode == 1) begin
                        c.cx = 16'($urandom); c.cy = 16'($urandom);
                    end else begin
                        c.cx = 16'(cxc + $signed($urandom_range(0, 2 * rad)) - rad);
                        c.cy = 16'(cyc + $signed($urandom_range(0, 2 * rad)) - rad);
                    end
                    c.first = (k == 0) && ($urandom_range(0, 19) != 0);
                    c.last = (k == ncorn - 1);
                    c.lshape = c.last ? (s == nshape - 1) : ($urandom_range(0, 9) == 0);
                    c.idx = 8'(idx);
                    if ($urandom_range(0, 49) == 0) begin
                        c.first = 1'($urandom); c.last = 1'($urandom);
                        c.lshape = 1'($urandom);
                    end
                    send_corner(c, calm ? 0 : pick_gap(), 0, none);
                    sent++;
                end
            end
        end

        item_if.valid <= 1'b0;
        drain();
        repeat (200) @(posedge i_clk);
        if (errors == 0 && hit_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
